@@ design/multi_channel_health_watchdog_macros.svh @@
// Assertion helpers for the health watchdog.
`ifndef MULTI_CHANNEL_HEALTH_WATCHDOG_MACROS_SVH
`define MULTI_CHANNEL_HEALTH_WATCHDOG_MACROS_SVH

// Implication that must hold at every clock edge outside reset.
`define MCHW_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define MCHW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ design/mchw_pkg.sv @@
package mchw_pkg;
  localparam int NUM_COMPONENTS = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W = 5;
  localparam int ELAPSED_W = 18;

  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_REG = 3'd1;
  localparam logic [2:0] MODE_UNREG = 3'd2;
  localparam logic [2:0] MODE_BEAT = 3'd3;
  localparam logic [2:0] MODE_ERROR = 3'd4;
  localparam logic [2:0] MODE_QUERY = 3'd5;

  localparam logic [1:0] ST_UNKNOWN = 2'd0;
  localparam logic [1:0] ST_HEALTHY = 2'd1;
  localparam logic [1:0] ST_DEGRADED = 2'd2;
  localparam logic [1:0] ST_UNHEALTHY = 2'd3;

  typedef struct packed {
    logic used;
    logic [1:0] status;
    logic [15:0] timeout;
    logic [ELAPSED_W-1:0] elapsed;
    logic [15:0] missed;
    logic [31:0] beats;
  } slot_rec_t;

  typedef struct packed {
    logic [CNT_W-1:0] healthy;
    logic [CNT_W-1:0] degraded;
    logic [CNT_W-1:0] unhealthy;
    logic [CNT_W-1:0] used;
  } agg_t;
endpackage

@@ design/mchw_agg.sv @@
// Running per-status counts over used slots, updated by status deltas.
module mchw_agg (
  input  logic clk,
  input  logic rst,
  input  logic upd,
  input  logic old_used,
  input  logic [1:0] old_st,
  input  logic new_used,
  input  logic [1:0] new_st,
  output mchw_pkg::agg_t agg,
  output logic [1:0] overall
);
  import mchw_pkg::*;

  agg_t agg_next;

  always_comb begin
    agg_next = agg;
    if (upd) begin
      if (old_used) begin
        agg_next.used = agg_next.used - CNT_W'(1);
        case (old_st)
          ST_HEALTHY: agg_next.healthy = agg_next.healthy - CNT_W'(1);
          ST_DEGRADED: agg_next.degraded = agg_next.degraded - CNT_W'(1);
          ST_UNHEALTHY: agg_next.unhealthy = agg_next.unhealthy - CNT_W'(1);
          default: ;
        endcase
      end
      if (new_used) begin
        agg_next.used = agg_next.used + CNT_W'(1);
        case (new_st)
          ST_HEALTHY: agg_next.healthy = agg_next.healthy + CNT_W'(1);
          ST_DEGRADED: agg_next.degraded = agg_next.degraded + CNT_W'(1);
          ST_UNHEALTHY: agg_next.unhealthy = agg_next.unhealthy + CNT_W'(1);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) agg <= '0;
    else agg <= agg_next;
  end

  always_comb begin
    if (agg.unhealthy != '0) overall = ST_UNHEALTHY;
    else if (agg.degraded != '0) overall = ST_DEGRADED;
    else if (agg.healthy != '0) overall = ST_HEALTHY;
    else overall = ST_UNKNOWN;
  end
endmodule

@@ design/multi_channel_health_watchdog.sv @@
// Channel | handshake                     | fields
// item    | start high while busy is low  | mode, slot, timeout_ticks
// result  | strobe, one cycle, no stall   | slot_index .. used_total, last
//
// A defined non-tick item is busy while it is read, modified and written back;
//   its one result is on the ports in the first cycle that busy reads low.
// A tick walks all 16 slots through the one read port and writes back each
//   update, then reads the slots again in a second pass and reports
//   every transition, so each result carries the totals of the whole tick.
// Reset clears the per-slot valid bits at once; no clearing pass.
// Results cannot be stalled by the receiver.
module multi_channel_health_watchdog (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [2:0] mode,
  input  logic [3:0] slot,
  input  logic [15:0] timeout_ticks,
  output logic strobe,
  output logic [3:0] slot_index,
  output logic [1:0] prior_status,
  output logic [1:0] next_status,
  output logic changed,
  output logic [15:0] missed_count,
  output logic [31:0] beat_count,
  output logic [1:0] worst_status,
  output logic [4:0] healthy_total,
  output logic [4:0] degraded_total,
  output logic [4:0] unhealthy_total,
  output logic [4:0] used_total,
  output logic last
);
  import mchw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_WR = 3'd2;
  localparam logic [2:0] S_OUT = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  // Slot memory; entries not yet written read through the valid bits.
  slot_rec_t mem [NUM_COMPONENTS];
  logic [NUM_COMPONENTS-1:0] vld;
  slot_rec_t rd_data;
  logic rd_vld;

  logic [2:0] state;
  logic [2:0] op;
  logic [SLOT_W-1:0] sl;
  logic [15:0] tmo;
  logic [SLOT_W:0] ridx;
  logic [SLOT_W-1:0] widx;
  logic wact;
  logic wact_scan;
  logic emit_rd;
  logic rpt;

  // Modify stage
  slot_rec_t cur, nrec;
  logic [1:0] ost, nst;
  logic chg, emit, valid_res;
  logic we;
  logic [17:0] t3;

  // Transitions found by the walk, reported by the second pass
  logic [NUM_COMPONENTS-1:0] hit, hit_rest;
  logic [1:0] hit_old [NUM_COMPONENTS];

  agg_t agg;
  logic [1:0] overall;
  logic agg_upd;

  mchw_agg u_agg (
    .clk(clk), .rst(rst), .upd(agg_upd),
    .old_used(cur.used), .old_st(cur.status),
    .new_used(nrec.used), .new_st(nrec.status),
    .agg(agg), .overall(overall)
  );

  // Read address: walked index or the addressed slot.
  logic [SLOT_W-1:0] raddr;
  logic re;
  assign raddr = (state == S_SCAN || state == S_EMIT) ? ridx[SLOT_W-1:0] : sl;
  assign re = (state == S_RD) || ((state == S_SCAN || state == S_EMIT) && !ridx[SLOT_W]);

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[raddr];
      rd_vld <= vld[raddr];
    end
    if (we) mem[widx] <= nrec;
  end

  always_comb begin
    cur = rd_vld ? rd_data : '0;
    nrec = cur;
    ost = cur.used ? cur.status : ST_UNKNOWN;
    chg = 1'b0;
    emit = 1'b0;
    t3 = 18'(cur.timeout) * 18'd3;
    if (op == MODE_TICK) begin
      if (cur.used) begin
        if (cur.elapsed != '1) nrec.elapsed = cur.elapsed + 18'd1;
        if (cur.timeout != '0) begin
          if (nrec.elapsed > t3) begin
            if (cur.status != ST_UNHEALTHY) begin
              nrec.status = ST_UNHEALTHY;
              emit = 1'b1;
            end
          end else if (nrec.elapsed > 18'(cur.timeout)) begin
            if (cur.status == ST_HEALTHY) begin
              nrec.status = ST_DEGRADED;
              emit = 1'b1;
            end
          end
          if (emit && cur.missed != '1) nrec.missed = cur.missed + 16'd1;
        end
      end
      chg = emit;
    end else begin
      unique case (op)
        MODE_REG: begin
          if (!cur.used) begin
            nrec.missed = '0;
            nrec.beats = '0;
          end
          nrec.used = 1'b1;
          nrec.timeout = tmo;
          nrec.status = ST_HEALTHY;
          nrec.elapsed = '0;
        end
        MODE_UNREG: nrec = '0;
        MODE_BEAT: begin
          if (cur.used) begin
            nrec.elapsed = '0;
            if (cur.beats != '1) nrec.beats = cur.beats + 32'd1;
            if (cur.status != ST_HEALTHY) begin
              nrec.status = ST_HEALTHY;
              nrec.missed = '0;
              chg = 1'b1;
            end
          end
        end
        MODE_ERROR: begin
          if (cur.used) begin
            nrec.status = ST_UNHEALTHY;
            chg = (cur.status != ST_UNHEALTHY);
          end
        end
        default: ;
      endcase
    end
    valid_res = nrec.used;
    nst = nrec.used ? nrec.status : ST_UNKNOWN;
  end

  // Write back in the write cycle of a single-slot item, or in the cycle after
  // each read of the walk.
  assign we = wact || wact_scan;
  assign agg_upd = we;

  // Report the slot just read in the second pass if the walk flagged it; it is
  // the last result when no flagged slot remains above it.
  assign rpt = emit_rd && hit[widx];

  always_comb begin
    hit_rest = hit;
    hit_rest[widx] = 1'b0;
  end

  // Registered result for non-tick items
  logic [1:0] r_old, r_new;
  logic r_chg;
  logic [15:0] r_miss;
  logic [31:0] r_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= MODE_QUERY;
      vld <= '0;
      wact <= 1'b0;
      hit <= '0;
      strobe <= 1'b0;
      last <= 1'b0;
      ridx <= '0;
    end else begin
      if (we) vld[widx] <= 1'b1;
      wact <= (state == S_WR);
      strobe <= (state == S_OUT) || rpt;
      last <= (state == S_OUT) || (rpt && hit_rest == '0);
      if (rpt) begin
        // Status, counters and totals are final once the walk is done.
        hit[widx] <= 1'b0;
        slot_index <= widx;
        prior_status <= hit_old[widx];
        next_status <= cur.status;
        changed <= 1'b1;
        missed_count <= cur.missed;
        beat_count <= cur.beats;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op <= mode;
            sl <= slot;
            tmo <= timeout_ticks;
            ridx <= '0;
            hit <= '0;
            if (mode == MODE_TICK) state <= S_SCAN;
            else if (mode <= MODE_QUERY) state <= S_RD;
          end
        end
        S_RD: begin
          widx <= sl;
          state <= S_WR;
        end
        S_WR: begin
          r_old <= ost;
          r_new <= nst;
          r_chg <= chg;
          r_miss <= valid_res ? nrec.missed : '0;
          r_beat <= valid_res ? nrec.beats : '0;
          state <= S_OUT;
        end
        S_OUT: begin
          // Aggregates include the write done at this edge.
          slot_index <= sl;
          prior_status <= r_old;
          next_status <= r_new;
          changed <= r_chg;
          missed_count <= r_miss;
          beat_count <= r_beat;
          state <= S_IDLE;
        end
        S_SCAN: begin
          // wact_scan marks the slot read last cycle, modified and written now.
          if (wact_scan && emit) begin
            hit[widx] <= 1'b1;
            hit_old[widx] <= ost;
          end
          if (!ridx[SLOT_W]) begin
            widx <= ridx[SLOT_W-1:0];
            ridx <= ridx + (SLOT_W+1)'(1);
          end else begin
            ridx <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!ridx[SLOT_W]) begin
            widx <= ridx[SLOT_W-1:0];
            ridx <= ridx + (SLOT_W+1)'(1);
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A slot read in either pass is handled the cycle after its read.
  always_ff @(posedge clk) begin
    if (rst) begin
      wact_scan <= 1'b0;
      emit_rd <= 1'b0;
    end else begin
      wact_scan <= (state == S_SCAN) && !ridx[SLOT_W];
      emit_rd <= (state == S_EMIT) && !ridx[SLOT_W];
    end
  end

  // Aggregates are sampled combinationally with each output strobe: they are
  // registered counts that already include every write of the item.
  assign worst_status = overall;
  assign healthy_total = agg.healthy;
  assign degraded_total = agg.degraded;
  assign unhealthy_total = agg.unhealthy;
  assign used_total = agg.used;

  assign busy = (state != S_IDLE);
endmodule

@@ design/mchw_checker.sv @@
module mchw_protocol_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic [2:0] mode,
  input logic strobe,
  input logic last,
  input logic [4:0] used_total,
  input logic [4:0] healthy_total,
  input logic [4:0] degraded_total,
  input logic [4:0] unhealthy_total
);
  import mchw_pkg::*;
`include "multi_channel_health_watchdog_macros.svh"

  logic [5:0] status_sum;
  assign status_sum = 6'(healthy_total) + 6'(degraded_total) + 6'(unhealthy_total);

  `MCHW_ASSERT_IMPL(a_last_strobe, clk, rst, last, strobe)
  `MCHW_ASSERT_IMPL(a_sum, clk, rst, strobe, status_sum == 6'(used_total))
  `MCHW_ASSERT_NEXT(a_busy_after_start, clk, rst, start && !busy && mode <= MODE_QUERY, busy)
  `MCHW_ASSERT_IMPL(a_used_max, clk, rst, strobe, used_total <= 5'd16)
endmodule

bind multi_channel_health_watchdog mchw_protocol_checker u_protocol_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .strobe(strobe),
  .last(last), .used_total(used_total), .healthy_total(healthy_total),
  .degraded_total(degraded_total), .unhealthy_total(unhealthy_total)
);

@@ bench/mchw_checker.sv @@
module mchw_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  mode,
  input  logic [3:0]  slot,
  input  logic [15:0] timeout_ticks,
  input  logic        strobe,
  input  logic [3:0]  slot_index,
  input  logic [1:0]  prior_status,
  input  logic [1:0]  next_status,
  input  logic        changed,
  input  logic [15:0] missed_count,
  input  logic [31:0] beat_count,
  input  logic [1:0]  worst_status,
  input  logic [4:0]  healthy_total,
  input  logic [4:0]  degraded_total,
  input  logic [4:0]  unhealthy_total,
  input  logic [4:0]  used_total,
  input  logic        last,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import mchw_pkg::*;

  localparam logic [ELAPSED_W-1:0] ELAPSED_TOP = '1;

  typedef struct packed {
    logic [3:0]  idx;
    logic [1:0]  prev_st;
    logic [1:0]  next_st;
    logic        chg;
    logic [15:0] missed;
    logic [31:0] beats;
    logic [1:0]  overall;
    logic [4:0]  n_healthy;
    logic [4:0]  n_degraded;
    logic [4:0]  n_unhealthy;
    logic [4:0]  n_used;
    logic        fin;
  } health_report_t;

  logic                 w_used    [NUM_COMPONENTS];
  logic [1:0]           w_status  [NUM_COMPONENTS];
  logic [15:0]          w_timeout [NUM_COMPONENTS];
  logic [ELAPSED_W-1:0] w_elapsed [NUM_COMPONENTS];
  logic [15:0]          w_missed  [NUM_COMPONENTS];
  logic [31:0]          w_beats   [NUM_COMPONENTS];

  health_report_t reports_due[$];

  function automatic health_report_t slot_view(int i, logic [1:0] prev, logic [1:0] nxt,
                                               logic chg, logic live);
    health_report_t r;
    r = '0;
    r.idx = i[3:0];
    r.prev_st = prev;
    r.next_st = nxt;
    r.chg = chg;
    r.missed = live ? w_missed[i] : 16'd0;
    r.beats = live ? w_beats[i] : 32'd0;
    return r;
  endfunction

  function automatic void predict_health(logic [2:0] m, logic [3:0] s, logic [15:0] tmo);
    health_report_t batch[$];
    health_report_t r;
    logic [1:0] prev;
    logic chg;
    int nh, nd, nu, nused;
    logic [1:0] worst;
    logic [19:0] lim;
    batch = {};
    if (m == MODE_TICK) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        if (!w_used[i]) continue;
        if (w_elapsed[i] != ELAPSED_TOP) w_elapsed[i] = w_elapsed[i] + 1'b1;
        if (w_timeout[i] == 16'd0) continue;
        prev = w_status[i];
        lim = 20'(w_timeout[i]) * 20'd3;
        if (20'(w_elapsed[i]) > lim) begin
          if (prev == ST_UNHEALTHY) continue;
          w_status[i] = ST_UNHEALTHY;
        end else if (20'(w_elapsed[i]) > 20'(w_timeout[i])) begin
          if (prev != ST_HEALTHY) continue;
          w_status[i] = ST_DEGRADED;
        end else begin
          continue;
        end
        if (w_missed[i] != 16'hFFFF) w_missed[i]++;
        batch = {batch, slot_view(i, prev, w_status[i], 1'b1, 1'b1)};
      end
    end else if (m <= MODE_QUERY) begin
      prev = w_used[s] ? w_status[s] : ST_UNKNOWN;
      chg = 1'b0;
      case (m)
        MODE_REG: begin
          if (!w_used[s]) begin
            w_missed[s] = '0;
            w_beats[s] = '0;
          end
          w_used[s] = 1'b1;
          w_timeout[s] = tmo;
          w_status[s] = ST_HEALTHY;
          w_elapsed[s] = '0;
        end
        MODE_UNREG: begin
          w_used[s] = 1'b0;
          w_status[s] = ST_UNKNOWN;
          w_timeout[s] = '0;
          w_elapsed[s] = '0;
          w_missed[s] = '0;
          w_beats[s] = '0;
        end
        MODE_BEAT: begin
          if (w_used[s]) begin
            w_elapsed[s] = '0;
            if (w_beats[s] != 32'hFFFF_FFFF) w_beats[s]++;
            if (w_status[s] != ST_HEALTHY) begin
              w_status[s] = ST_HEALTHY;
              w_missed[s] = '0;
              chg = 1'b1;
            end
          end
        end
        MODE_ERROR: begin
          if (w_used[s]) begin
            w_status[s] = ST_UNHEALTHY;
            chg = (prev != ST_UNHEALTHY);
          end
        end
        default: ;
      endcase
      batch = {batch, slot_view(s, prev, w_used[s] ? w_status[s] : ST_UNKNOWN, chg,
                                w_used[s])};
    end
    nh = 0; nd = 0; nu = 0; nused = 0;
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      if (!w_used[i]) continue;
      nused++;
      if (w_status[i] == ST_HEALTHY) nh++;
      else if (w_status[i] == ST_DEGRADED) nd++;
      else if (w_status[i] == ST_UNHEALTHY) nu++;
    end
    worst = nu > 0 ? ST_UNHEALTHY : nd > 0 ? ST_DEGRADED : nh > 0 ? ST_HEALTHY : ST_UNKNOWN;
    foreach (batch[k]) begin
      r = batch[k];
      r.overall = worst;
      r.n_healthy = 5'(nh);
      r.n_degraded = 5'(nd);
      r.n_unhealthy = 5'(nu);
      r.n_used = 5'(nused);
      r.fin = (k == batch.size() - 1);
      reports_due = {reports_due, r};
    end
  endfunction

  function automatic void cmp(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    health_report_t e;
    if (rst) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        w_used[i] = 1'b0;
        w_status[i] = ST_UNKNOWN;
        w_timeout[i] = '0;
        w_elapsed[i] = '0;
        w_missed[i] = '0;
        w_beats[i] = '0;
      end
      reports_due = {};
      fail_count = 0;
      checked = 0;
    end else begin
      // compare first: a result never shares its edge with the item that caused it
      if (strobe) begin
        if (reports_due.size() == 0) begin
          $error("result for slot %0d arrived with nothing expected", slot_index);
          fail_count++;
        end else begin
          e = reports_due.pop_front();
          checked++;
          cmp("slot_index", e.idx, slot_index);
          cmp("prior_status", e.prev_st, prior_status);
          cmp("next_status", e.next_st, next_status);
          cmp("changed", e.chg, changed);
          cmp("missed_count", e.missed, missed_count);
          cmp("beat_count", e.beats, beat_count);
          cmp("worst_status", e.overall, worst_status);
          cmp("healthy_total", e.n_healthy, healthy_total);
          cmp("degraded_total", e.n_degraded, degraded_total);
          cmp("unhealthy_total", e.n_unhealthy, unhealthy_total);
          cmp("used_total", e.n_used, used_total);
          cmp("last", e.fin, last);
        end
      end
      if (start && !busy) predict_health(mode, slot, timeout_ticks);
    end
    pending = reports_due.size();
  end
endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mchw_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 160;
  localparam int CALM_TAIL = 30;  // final items sent back to back
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] mode = MODE_QUERY;
  logic [3:0] slot = '0;
  logic [15:0] timeout_ticks = '0;
  logic strobe;
  logic [3:0] slot_index;
  logic [1:0] prior_status, next_status;
  logic changed, last;
  logic [15:0] missed_count;
  logic [31:0] beat_count;
  logic [1:0] worst_status;
  logic [4:0] healthy_total, degraded_total, unhealthy_total, used_total;
  int fail_count, pending, checked;
  int items_sent = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  multi_channel_health_watchdog i_dut (.*);

  mchw_checker i_checker (.*);

  // Abort if the handshake goes silent: neither an item taken nor a result seen.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one item at the current edge and hold it until taken; optionally go idle after.
  task automatic send_item(logic [2:0] m, logic [3:0] s, logic [15:0] tmo, int idle);
    logic taken;
    start <= 1'b1;
    mode <= m;
    slot <= s;
    timeout_ticks <= tmo;
    do begin
      @(negedge clk);
      taken = !busy;  // busy is stable from the falling edge to the next rising edge
      @(posedge clk);
    end while (!taken);
    items_sent++;
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  function automatic int pick_idle(int n);
    if (n >= RANDOM_ITEMS - CALM_TAIL) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 12);
    return 0;
  endfunction

  initial begin
    logic [2:0] m;
    logic [15:0] tmo;
    int roll;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of timeout, each operation, unused-slot and repeat cases.
    send_item(MODE_REG, 4'd0, 16'd1, 0);
    send_item(MODE_REG, 4'd15, 16'hFFFF, 0);
    send_item(MODE_REG, 4'd3, 16'd0, 3);        // watchdog disabled on slot 3
    send_item(MODE_QUERY, 4'd0, 16'd0, 0);
    send_item(MODE_TICK, 4'd9, 16'd0, 0);       // no transition: no result
    send_item(MODE_TICK, 4'd0, 16'd0, 0);       // slot 0 goes degraded
    send_item(MODE_TICK, 4'd0, 16'd0, 0);       // at three timeouts: no change yet
    send_item(MODE_TICK, 4'd0, 16'd0, 0);       // slot 0 goes unhealthy
    send_item(MODE_BEAT, 4'd0, 16'd0, 0);       // recovery clears missed
    send_item(MODE_BEAT, 4'd0, 16'd0, 0);       // already healthy
    send_item(MODE_ERROR, 4'd15, 16'd0, 0);
    send_item(MODE_ERROR, 4'd15, 16'd0, 0);     // already unhealthy
    send_item(MODE_BEAT, 4'd7, 16'd0, 0);       // unused slot
    send_item(MODE_ERROR, 4'd7, 16'd0, 0);
    send_item(MODE_QUERY, 4'd7, 16'd0, 0);
    send_item(MODE_UNREG, 4'd7, 16'd0, 0);
    send_item(MODE_REG, 4'd0, 16'd2, 0);        // re-register keeps counters
    send_item(MODE_UNREG, 4'd15, 16'd0, 0);
    send_item(MODE_SPARE_A, 4'd2, 16'hFFFF, 5); // undefined modes are dropped
    send_item(MODE_SPARE_B, 4'd5, 16'h5555, 0);
    send_item(MODE_TICK, 4'd0, 16'd0, 0);
    send_item(MODE_QUERY, 4'd3, 16'hAAAA, 0);

    // Random: small timeouts so ticks drive real transitions, plus noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) m = MODE_TICK;
      else if (roll < 50) m = MODE_REG;
      else if (roll < 56) m = MODE_UNREG;
      else if (roll < 76) m = MODE_BEAT;
      else if (roll < 86) m = MODE_ERROR;
      else if (roll < 95) m = MODE_QUERY;
      else m = ($urandom_range(0, 1) == 0) ? MODE_SPARE_A : MODE_SPARE_B;
      if (m == MODE_REG && $urandom_range(0, 5) != 0) tmo = 16'($urandom_range(0, 4));
      else tmo = 16'($urandom());
      send_item(m, 4'($urandom_range(0, 15)), tmo, pick_idle(n));
    end
    start <= 1'b0;

    // Drain: wait out pending results, then the longest scan.
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);

    $display("Sent %0d items (ticks, registrations, beats, errors, queries, undefined modes);",
             items_sent);
    $display("checked %0d status reports field by field.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
